[rtl/fir_decimate_by_two_top_defines.svh]
// Assertion macros for the decimating FIR top level.
`ifndef FIR_DECIMATE_BY_TWO_TOP_DEFINES_SVH
`define FIR_DECIMATE_BY_TWO_TOP_DEFINES_SVH

// Check a consequence in the same cycle; expects clk and arst_n in scope.
`define FDEC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the next cycle; expects clk and arst_n in scope.
`define FDEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/fdec_pkg.sv]
// Constants, coefficient table and shared types of the decimating FIR.
package fdec_pkg;

	localparam int TAP_COUNT  = 63;
	localparam int DECIMATION = 2;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int FRAC       = COEF_W - 1;
	localparam int ACC_W      = SAMPLE_W + COEF_W + $clog2(TAP_COUNT);
	localparam int TAP_IDX_W  = $clog2(TAP_COUNT);
	localparam int PHASE_W    = $clog2(DECIMATION);
	localparam int CENTER     = (TAP_COUNT - 1) / 2;
	localparam int OUT_MAX    = 32767;
	localparam int OUT_MIN    = -32768;

	// Center tap and one side of the symmetric Q1.15 windowed sinc
	localparam logic signed [COEF_W-1:0] DESIGN_HALF [32] = '{
		16'sd14350,  16'sd10216,   16'sd1979,  -16'sd2833,
		-16'sd1777,   16'sd1093,   16'sd1475,   -16'sd259,
		-16'sd1118,   -16'sd186,    16'sd756,    16'sd392,
		 -16'sd430,   -16'sd438,    16'sd174,    16'sd385,
		    16'sd0,   -16'sd283,    -16'sd94,    16'sd174,
		  16'sd125,    -16'sd82,   -16'sd113,     16'sd20,
		   16'sd83,     16'sd13,    -16'sd51,    -16'sd25,
		   16'sd27,     16'sd27,    -16'sd11,    -16'sd26
	};

	// Controls handed from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic valid;
		logic last;
	} mac_ctrl_t;

	// Look up the coefficient of tap k by its distance from the center
	function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_IDX_W-1:0] k);
		logic [TAP_IDX_W-1:0] d;
		if (k >= TAP_IDX_W'(CENTER)) begin
			d = k - TAP_IDX_W'(CENTER);
		end else begin
			d = TAP_IDX_W'(CENTER) - k;
		end
		return DESIGN_HALF[d[4:0]];
	endfunction

endpackage

[rtl/fdec_in_if.sv]
// Input stream channel carrying raw PCM samples.
interface fdec_in_if;
	import fdec_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] raw_sample;

	modport source (output valid, output raw_sample, input ready);
	modport sink (input valid, input raw_sample, output ready);
endinterface

[rtl/fdec_out_if.sv]
// Output stream channel carrying filtered, decimated samples.
interface fdec_out_if;
	import fdec_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] filtered_sample;

	modport source (output valid, output filtered_sample, input ready);
	modport sink (input valid, input filtered_sample, output ready);
endinterface

[rtl/fdec_cell.sv]
// One sample cell of the history ring: loads its neighbor's value on shift.
module fdec_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift,
	input  logic signed [fdec_pkg::SAMPLE_W-1:0] d,
	output logic signed [fdec_pkg::SAMPLE_W-1:0] q
);
	import fdec_pkg::*;

	logic signed [SAMPLE_W-1:0] sample_q;

	// Take the neighbor's sample on shift, hold otherwise; history starts silent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;
endmodule

[rtl/fdec_mac.sv]
// Pipelined multiply-accumulate with round-half-even and 16-bit saturation.
module fdec_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fdec_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [fdec_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [fdec_pkg::COEF_W-1:0]   coef,
	output logic                                done,
	output logic signed [fdec_pkg::SAMPLE_W-1:0] result
);
	import fdec_pkg::*;

	localparam int Q_W  = ACC_W - FRAC;
	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam logic [FRAC-1:0] HALF = {1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(OUT_MAX);
	localparam logic signed [Q_W-1:0] SAT_LO = Q_W'(OUT_MIN);

	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [COEF_W-1:0]   coef_s1;
	logic                       vld_s1;
	logic                       last_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       vld_s2;
	logic                       last_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       done_q;

	logic signed [Q_W-1:0]      q_floor;
	logic [FRAC-1:0]            rem;
	logic                       round_up;
	logic signed [Q_W-1:0]      q_round;

	// Control flags of the operand and product stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= ctrl.valid;
			last_s1 <= ctrl.last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	// Register operands, then the product
	always_ff @(posedge clk) begin
		sample_s1 <= sample;
		coef_s1   <= coef;
		prod_s2   <= sample_s1 * coef_s1;
	end

	// Accumulate products; flag completion on the last tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			done_q <= 1'b0;
		end else if (ctrl.clear) begin
			acc_q  <= '0;
			done_q <= 1'b0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
			if (last_s2) begin
				done_q <= 1'b1;
			end
		end
	end

	// Round to nearest, ties to even, then saturate
	always_comb begin
		q_floor  = acc_q[ACC_W-1:FRAC];
		rem      = acc_q[FRAC-1:0];
		round_up = (rem > HALF) || ((rem == HALF) && q_floor[0]);
		q_round  = q_floor + Q_W'(round_up);
		if (q_round > SAT_HI) begin
			result = SAMPLE_W'(SAT_HI);
		end else if (q_round < SAT_LO) begin
			result = SAMPLE_W'(SAT_LO);
		end else begin
			result = q_round[SAMPLE_W-1:0];
		end
	end

	assign done = done_q;
endmodule

[rtl/fir_decimate_by_two_top.sv]
// Top level of the 63-tap low-pass FIR with 2:1 decimation.
`include "fir_decimate_by_two_top_defines.svh"

// Every raw sample shifts into a ring of 63 sample cells holding the latest
// window. The first sample of each pair also produces one filtered sample:
// the ring rotates once through all 63 cells while a single pipelined
// multiplier steps through the coefficients, one tap a cycle. While a sample
// is filtered (tap rotation, multiplier pipeline drain, output load), no new
// input is taken; a sample that produces no output needs no rotation. A
// finished sample waits in an output register, and the next input is taken
// meanwhile. After reset the history reads as silence.
module fir_decimate_by_two_top (
	input  logic        clk,
	input  logic        arst_n,
	fdec_in_if.sink     raw,
	fdec_out_if.source  filtered
);
	import fdec_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(TAP_COUNT - 1);
	localparam logic [PHASE_W-1:0]   LAST_PHASE = PHASE_W'(DECIMATION - 1);

	logic [1:0]                 state_q;
	logic [TAP_IDX_W-1:0]       tap_cnt_q;
	logic [PHASE_W-1:0]         phase_q;
	logic                       accept;
	logic                       emit;
	logic                       rotating;
	logic                       shift_en;
	logic                       out_load;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] filtered_q;
	logic signed [SAMPLE_W-1:0] hist [TAP_COUNT];
	logic signed [SAMPLE_W-1:0] next_d [TAP_COUNT];
	mac_ctrl_t                  mac_ctrl;
	logic                       mac_done;
	logic signed [SAMPLE_W-1:0] mac_result;

	assign raw.ready = (state_q == ST_IDLE);
	assign accept    = raw.valid && raw.ready;
	assign emit      = (phase_q == '0);
	assign rotating  = (state_q == ST_RUN);
	assign shift_en  = accept || rotating;
	assign out_load  = (state_q == ST_WAIT) && mac_done && (!out_valid_q || filtered.ready);

	// Feed each cell from its neighbor; the end cell takes new input or closes the ring
	always_comb begin
		for (int i = 0; i < TAP_COUNT - 1; i++) begin
			next_d[i] = hist[i+1];
		end
		next_d[TAP_COUNT-1] = rotating ? hist[0] : raw.raw_sample;
	end

	// Sample ring
	for (genvar g = 0; g < TAP_COUNT; g++) begin : g_cell
		fdec_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift_en),
			.d      (next_d[g]),
			.q      (hist[g])
		);
	end

	// Drive the multiply-accumulate unit from the ring head
	assign mac_ctrl.clear = accept && emit;
	assign mac_ctrl.valid = rotating;
	assign mac_ctrl.last  = rotating && (tap_cnt_q == LAST_TAP);

	fdec_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (hist[0]),
		.coef   (tap_coef(tap_cnt_q)),
		.done   (mac_done),
		.result (mac_result)
	);

	// Sequencer: idle, rotate through the taps, wait for the sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tap_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					tap_cnt_q <= '0;
					if (accept && emit) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tap_cnt_q == LAST_TAP) begin
						state_q <= ST_WAIT;
					end else begin
						tap_cnt_q <= tap_cnt_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Advance the decimation phase on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= (phase_q == LAST_PHASE) ? '0 : phase_q + 1'b1;
		end
	end

	// Output register: load a finished sample, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (filtered.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q <= mac_result;
		end
	end

	assign filtered.valid           = out_valid_q;
	assign filtered.filtered_sample = filtered_q;

	`FDEC_ASSERT_NEXT(a_emit_starts_run, accept && emit, state_q == ST_RUN, "emitting sample did not start the tap rotation")
	`FDEC_ASSERT_NEXT(a_skip_stays_idle, accept && !emit, state_q == ST_IDLE, "non-emitting sample left the idle state")
	`FDEC_ASSERT_NOW(a_no_done_in_run, state_q == ST_RUN, !mac_done, "sum reported complete during rotation")
	`FDEC_ASSERT_NOW(a_out_from_wait, $rose(out_valid_q), $past(state_q) == ST_WAIT, "output appeared without a finished sum")
endmodule

[test/tb_fir_decimate_by_two_top.sv]
// Self-checking testbench for the 63-tap decimate-by-two low-pass FIR.
module tb_fir_decimate_by_two_top;
	import fdec_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 120;
	localparam logic signed [SAMPLE_W-1:0] FULL_POS = SAMPLE_W'(OUT_MAX);
	localparam logic signed [SAMPLE_W-1:0] FULL_NEG = SAMPLE_W'(OUT_MIN);
	localparam longint HALF_LSB = longint'(1) <<< (FRAC - 1);

	// Kinds of sample sequences used by the random traffic
	typedef enum int {
		SEQ_NOISE,
		SEQ_MATCHED,
		SEQ_TIES,
		SEQ_DC,
		SEQ_SMALL,
		SEQ_ALTERNATE
	} seq_kind_e;

	logic clk;
	logic arst_n;

	fdec_in_if  raw_if ();
	fdec_out_if filt_if ();

	fir_decimate_by_two_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw      (raw_if),
		.filtered (filt_if)
	);

	// Filter state mirrored from the block: oldest sample at index 0
	logic signed [SAMPLE_W-1:0] pcm_window [TAP_COUNT-1];
	int                         pair_slot;
	logic signed [SAMPLE_W-1:0] filtered_q [$];

	int  bad_filtered;
	bit  idle_on;
	int  hold_request;
	int  quiet_cycles;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Weight of tap k in Q1.15, symmetric around the center tap
	function automatic longint tap_weight(input int k);
		int d;
		d = (k >= CENTER) ? k - CENTER : CENTER - k;
		return longint'(DESIGN_HALF[d]);
	endfunction

	// Shift one sample into the window; on the first of each pair queue the output
	function automatic void fir_decimate_step(input logic signed [SAMPLE_W-1:0] x);
		longint acc;
		longint q;
		longint rem;
		if (pair_slot == 0) begin
			acc = tap_weight(TAP_COUNT - 1) * longint'(x);
			for (int k = 0; k < TAP_COUNT - 1; k++) begin
				acc += tap_weight(k) * longint'(pcm_window[k]);
			end
			// round to nearest, ties to even, then clamp
			q = acc >>> FRAC;
			rem = acc - (q <<< FRAC);
			if (rem > HALF_LSB || (rem == HALF_LSB && q[0])) begin
				q++;
			end
			if (q > OUT_MAX) begin
				q = OUT_MAX;
			end
			if (q < OUT_MIN) begin
				q = OUT_MIN;
			end
			filtered_q.push_back(SAMPLE_W'(q));
		end
		for (int k = 0; k < TAP_COUNT - 2; k++) begin
			pcm_window[k] = pcm_window[k+1];
		end
		pcm_window[TAP_COUNT-2] = x;
		pair_slot = (pair_slot + 1) % DECIMATION;
	endfunction

	// Offer one sample, after a random gap if idle_on is set, and hold it until accepted
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			raw_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw_if.valid      <= 1'b1;
		raw_if.raw_sample <= x;
		do @(posedge clk); while (!raw_if.ready);
		fir_decimate_step(x);
	endtask

	// Feed a full window whose signs follow the taps, so the output made by its last sample clips
	task automatic send_matched_window(input bit negative);
		longint w;
		if (pair_slot != 0) begin
			send_sample(SAMPLE_W'($urandom));
		end
		for (int k = 0; k < TAP_COUNT; k++) begin
			w = tap_weight(k);
			if (w == 0) begin
				send_sample(SAMPLE_W'($urandom));
			end else if ((w > 0) != negative) begin
				send_sample(FULL_POS);
			end else begin
				send_sample(FULL_NEG);
			end
		end
	endtask

	// Silent history after reset; the first output is an exact tie (-6.5)
	task automatic test_reset_silence();
		send_sample(16'sd8192);
		send_sample(16'sd0);
		send_sample(16'sd0);
		send_sample(16'sd0);
	endtask

	// Full-scale and bit-pattern samples on both phases of the pair
	task automatic test_extremes();
		send_sample(FULL_POS);
		send_sample(FULL_NEG);
		send_sample(FULL_NEG);
		send_sample(FULL_POS);
		send_sample(16'sh5555);
		send_sample(16'shaaaa);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sd24576);
		send_sample(-16'sd8192);
	endtask

	// Mixed sequences: noise, clipping windows, tie patterns, DC, tiny, alternating
	task automatic test_random_traffic(input int n_items);
		int                         sent;
		int                         len;
		int                         m;
		seq_kind_e                  kind;
		logic signed [SAMPLE_W-1:0] level;
		logic signed [SAMPLE_W-1:0] x;
		sent = 0;
		while (sent < n_items) begin
			kind = seq_kind_e'($urandom_range(0, 5));
			if (kind == SEQ_MATCHED) begin
				send_matched_window(1'($urandom_range(0, 1)));
				sent += TAP_COUNT;
			end else begin
				len = $urandom_range(16, 80);
				level = SAMPLE_W'($urandom);
				if (kind == SEQ_DC && $urandom_range(0, 1)) begin
					level = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
				end
				for (int i = 0; i < len; i++) begin
					case (kind)
						SEQ_TIES: begin
							m = int'($urandom_range(0, 31)) - 16;
							x = SAMPLE_W'(m * 2048);
						end
						SEQ_DC: begin
							x = level;
						end
						SEQ_SMALL: begin
							x = SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
						end
						SEQ_ALTERNATE: begin
							x = (i % 2) ? -level : level;
						end
						default: begin
							x = SAMPLE_W'($urandom);
						end
					endcase
					send_sample(x);
				end
				sent += len;
			end
		end
	endtask

	// Hold the output off for a long stretch while samples keep coming
	task automatic test_output_stall();
		hold_request = 400;
		for (int i = 0; i < 40; i++) begin
			send_sample(SAMPLE_W'($urandom));
		end
	endtask

	// Stop sending until every queued output has come out, then resume
	task automatic test_input_pause();
		raw_if.valid <= 1'b0;
		do @(posedge clk); while (filtered_q.size() != 0);
		for (int i = 0; i < 20; i++) begin
			send_sample(SAMPLE_W'($urandom));
		end
	endtask

	// Output side: random stalls while idle_on is set, plus the long hold-off on request
	initial begin
		int stall;
		filt_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request > 0) begin
				filt_if.ready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
			end
			stall = idle_on ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				filt_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			filt_if.ready <= 1'b1;
			do @(posedge clk); while (!filt_if.valid && hold_request == 0);
		end
	end

	// Compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n && filt_if.valid && filt_if.ready) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected filtered_sample, expected none, actual %0d",
					$time, filt_if.filtered_sample);
				bad_filtered++;
			end else begin
				want = filtered_q.pop_front();
				if (filt_if.filtered_sample !== want) begin
					$display("%0t: filtered_sample mismatch, expected %0d, actual %0d",
						$time, want, filt_if.filtered_sample);
					bad_filtered++;
				end
			end
		end
	end

	// Watchdog: end the run if no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((raw_if.valid && raw_if.ready) || (filt_if.valid && filt_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		raw_if.valid      <= 1'b0;
		raw_if.raw_sample <= '0;
		bad_filtered = 0;
		hold_request = 0;
		idle_on = 1'b1;
		pair_slot = 0;
		for (int k = 0; k < TAP_COUNT - 1; k++) begin
			pcm_window[k] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_silence();
		test_extremes();
		test_random_traffic(200);
		idle_on = 1'b0;
		test_random_traffic(100);
		idle_on = 1'b1;
		test_output_stall();
		test_input_pause();
		test_random_traffic(150);

		// Let the block drain, then allow for any stray output
		raw_if.valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_filtered == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
